### rtl/asc_pkg.sv
// Package for the aliquot sum classifier: widths, limits, result classes
// and sequencer states. No dependencies.
package asc_pkg;

   localparam int NUMBER_WIDTH_DEFAULT = 16;
   localparam int ABUND_WIDTH          = 19;
   localparam int ABUND_MAX            = 262143;
   localparam int ABUND_MIN            = -262144;

   typedef enum logic [1:0] {
      CLASS_ABUNDANT  = 2'd0,
      CLASS_PERFECT   = 2'd1,
      CLASS_DEFICIENT = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_FINISH
   } state_type;

endpackage

### rtl/aliquot_sum_classifier_core.sv
// Aliquot sum classifier: sums the proper divisors of a number and reports
// abundance and class. Depends on asc_pkg.
//
// One number is taken per run; req_stall stays high until the result has
// been moved to the output register. For number n >= 2 every candidate
// d = 1 .. n-1 goes through one serial restoring divider that produces one
// remainder bit per cycle, then a check state adds d to the sum when the
// remainder is zero; 0 and 1 skip the divider and go straight to finish.
// The result register holds one beat, so the next number is accepted while
// the previous result waits on rsp_stall. Abundance saturates to 19 bits;
// the class always follows the exact value.
module aliquot_sum_classifier_core #(
   parameter int NUMBER_WIDTH = asc_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [NUMBER_WIDTH-1:0]          req_number,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_number_class,
   output logic signed [asc_pkg::ABUND_WIDTH-1:0] rsp_abundance
);

   localparam int SUM_W = NUMBER_WIDTH + 3;
   localparam int AB_W  = NUMBER_WIDTH + 4;
   localparam int EXT_W = (AB_W > asc_pkg::ABUND_WIDTH) ? AB_W : asc_pkg::ABUND_WIDTH;
   localparam int CNT_W = $clog2(NUMBER_WIDTH);
   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(asc_pkg::ABUND_MAX);
   localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(asc_pkg::ABUND_MIN);

   asc_pkg::state_type state_ff, state_in;

   logic [NUMBER_WIDTH-1:0] n_ff, n_in;
   logic [NUMBER_WIDTH-1:0] d_ff, d_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;

   logic                                   out_valid_ff, out_valid_in;
   asc_pkg::class_type                     out_class_ff, out_class_in;
   logic signed [asc_pkg::ABUND_WIDTH-1:0] out_ab_ff, out_ab_in;

   logic [NUMBER_WIDTH:0]   trial;
   logic [NUMBER_WIDTH-1:0] diff;
   logic                    fits;
   logic                    accept;
   logic                    out_free;
   logic signed [AB_W-1:0]  ab;
   logic signed [EXT_W-1:0] ab_ext;

   // shared divider step
   assign trial = {rem_ff, shift_ff[NUMBER_WIDTH-1]};
   assign fits  = trial >= {1'b0, d_ff};
   assign diff  = trial[NUMBER_WIDTH-1:0] - d_ff;

   assign ab     = $signed({1'b0, sum_ff}) - $signed({4'b0000, n_ff});
   assign ab_ext = EXT_W'(ab);

   assign req_stall = (state_ff != asc_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_class_in = out_class_ff;
      out_ab_in    = out_ab_ff;
      unique case (state_ff)
         asc_pkg::ST_IDLE: begin
            if (accept) begin
               n_in     = req_number;
               d_in     = NUMBER_WIDTH'(1);
               rem_in   = '0;
               shift_in = req_number;
               cnt_in   = '0;
               sum_in   = '0;
               if (req_number > NUMBER_WIDTH'(1)) begin
                  state_in = asc_pkg::ST_DIV;
               end else begin
                  state_in = asc_pkg::ST_FINISH;
               end
            end
         end
         asc_pkg::ST_DIV: begin
            rem_in   = fits ? diff : trial[NUMBER_WIDTH-1:0];
            shift_in = shift_ff << 1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUMBER_WIDTH - 1)) begin
               state_in = asc_pkg::ST_CHECK;
            end
         end
         asc_pkg::ST_CHECK: begin
            if (rem_ff == '0) begin
               sum_in = sum_ff + SUM_W'(d_ff);
            end
            if (d_ff == n_ff - NUMBER_WIDTH'(1)) begin
               state_in = asc_pkg::ST_FINISH;
            end else begin
               d_in     = d_ff + NUMBER_WIDTH'(1);
               rem_in   = '0;
               shift_in = n_ff;
               cnt_in   = '0;
               state_in = asc_pkg::ST_DIV;
            end
         end
         asc_pkg::ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               priority if (ab > 0) begin
                  out_class_in = asc_pkg::CLASS_ABUNDANT;
               end else if (ab == 0) begin
                  out_class_in = asc_pkg::CLASS_PERFECT;
               end else begin
                  out_class_in = asc_pkg::CLASS_DEFICIENT;
               end
               priority if (ab_ext > SAT_HI) begin
                  out_ab_in = SAT_HI[asc_pkg::ABUND_WIDTH-1:0];
               end else if (ab_ext < SAT_LO) begin
                  out_ab_in = SAT_LO[asc_pkg::ABUND_WIDTH-1:0];
               end else begin
                  out_ab_in = ab_ext[asc_pkg::ABUND_WIDTH-1:0];
               end
               state_in = asc_pkg::ST_IDLE;
            end
         end
         default: state_in = asc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asc_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      d_ff         <= d_in;
      rem_ff       <= rem_in;
      shift_ff     <= shift_in;
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      out_class_ff <= out_class_in;
      out_ab_ff    <= out_ab_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_number_class = out_class_ff;
   assign rsp_abundance    = out_ab_ff;

endmodule

### rtl/asc_checker.sv
// Port-level checks for aliquot_sum_classifier_core, with its bind.
// Depends on asc_pkg.
module asc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [1:0]                             rsp_number_class,
   input logic signed [asc_pkg::ABUND_WIDTH-1:0] rsp_abundance
);

   // one number in flight: busy right after a beat is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a second request back to back");

   a_class_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_number_class != 2'd3)
      else $error("unused class code");

   a_perfect_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_number_class == asc_pkg::CLASS_PERFECT |-> rsp_abundance == '0)
      else $error("perfect with nonzero abundance");

   a_sign_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_abundance[asc_pkg::ABUND_WIDTH-1] ==
                     (rsp_number_class == asc_pkg::CLASS_DEFICIENT)))
      else $error("abundance sign does not match class");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_abundance)
                                 && $stable(rsp_number_class))
      else $error("stalled response changed");

endmodule

bind aliquot_sum_classifier_core asc_checker u_asc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_number_class (rsp_number_class),
   .rsp_abundance    (rsp_abundance)
);
